>>> rtl/ple_pkg.sv
package ple_pkg;

   localparam int CAPACITY = 16;

   localparam int ACTION_W = 2;
   localparam int POS_W    = 5;
   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic             op_go;
      logic             elem_go;
      logic [IDX_W-1:0] elem_idx;
      logic             elem_last;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
   } stat_type;

endpackage

>>> rtl/ple_ctrl.sv
module ple_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ple_pkg::ACTION_W-1:0]  req_action,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output ple_pkg::cmd_type              cmd,
   input  ple_pkg::stat_type             stat
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_DUMP = 1'b1;

   logic                        state_ff, state_in;
   logic [ple_pkg::IDX_W-1:0]   idx_ff, idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        slot_free;
   logic                        accept;
   logic                        dump_list;
   logic                        elem_last;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE) || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign dump_list = (req_action == ple_pkg::ACT_DUMP) && (stat.count != '0);
   assign elem_last = (ple_pkg::CNT_W'(idx_ff) + ple_pkg::CNT_W'(1)) == stat.count;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.op_go     = accept && !dump_list;
      cmd.elem_go   = (state_ff == S_DUMP) && slot_free;
      cmd.elem_idx  = idx_ff;
      cmd.elem_last = elem_last;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && dump_list) begin
               state_in = S_DUMP;
               idx_in   = '0;
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               if (elem_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + ple_pkg::IDX_W'(1);
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op_go || cmd.elem_go) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/ple_datapath.sv
module ple_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ple_pkg::cmd_type              cmd,
   output ple_pkg::stat_type             stat,
   input  logic [ple_pkg::ACTION_W-1:0]  req_action,
   input  logic [ple_pkg::POS_W-1:0]     req_position,
   input  logic [ple_pkg::VALUE_W-1:0]   req_item_value,
   output logic [ple_pkg::VALUE_W-1:0]   rsp_element_value,
   output logic                          rsp_has_element,
   output logic [ple_pkg::COUNT_W-1:0]   rsp_element_count,
   output logic [ple_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last_result
);

   logic [ple_pkg::VALUE_W-1:0]  entries_ff [ple_pkg::CAPACITY];
   logic [ple_pkg::VALUE_W-1:0]  entries_in [ple_pkg::CAPACITY];
   logic [ple_pkg::CNT_W-1:0]    count_ff, count_in;

   logic [ple_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                         has_ff, has_in;
   logic [ple_pkg::COUNT_W-1:0]  rcount_ff, rcount_in;
   logic [ple_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         last_ff, last_in;

   logic [ple_pkg::CMP_W-1:0]    pos_ext;
   logic [ple_pkg::CMP_W-1:0]    cnt_ext;
   logic [ple_pkg::CMP_W-1:0]    cnt_next_ext;
   logic                         ins_range;
   logic                         rem_range;
   logic                         full;
   logic [ple_pkg::STATUS_W-1:0] op_status;

   assign pos_ext      = ple_pkg::CMP_W'(req_position);
   assign cnt_ext      = ple_pkg::CMP_W'(count_ff);
   assign cnt_next_ext = ple_pkg::CMP_W'(count_in);
   assign ins_range    = pos_ext > cnt_ext;
   assign rem_range    = pos_ext >= cnt_ext;
   assign full         = count_ff == ple_pkg::CNT_W'(ple_pkg::CAPACITY);

   assign stat.count = count_ff;

   // list update: all entries shift in parallel
   always_comb begin
      entries_in = entries_ff;
      count_in   = count_ff;
      op_status  = ple_pkg::ST_OK;
      if (cmd.op_go) begin
         unique case (req_action)
            ple_pkg::ACT_INSERT: begin
               if (ins_range) begin
                  op_status = ple_pkg::ST_RANGE;
               end else if (full) begin
                  op_status = ple_pkg::ST_FULL;
               end else begin
                  if (pos_ext == '0) begin
                     entries_in[0] = req_item_value;
                  end
                  for (int i = 1; i < ple_pkg::CAPACITY; i++) begin
                     if (ple_pkg::CMP_W'(i) == pos_ext) begin
                        entries_in[i] = req_item_value;
                     end else if (ple_pkg::CMP_W'(i) > pos_ext) begin
                        entries_in[i] = entries_ff[i-1];
                     end
                  end
                  count_in = count_ff + ple_pkg::CNT_W'(1);
               end
            end
            ple_pkg::ACT_REMOVE: begin
               if (rem_range) begin
                  op_status = ple_pkg::ST_RANGE;
               end else begin
                  for (int i = 0; i < ple_pkg::CAPACITY - 1; i++) begin
                     if (ple_pkg::CMP_W'(i) >= pos_ext) begin
                        entries_in[i] = entries_ff[i+1];
                     end
                  end
                  count_in = count_ff - ple_pkg::CNT_W'(1);
               end
            end
            ple_pkg::ACT_CLEAR: begin
               count_in = '0;
            end
            ple_pkg::ACT_DUMP: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      value_in  = value_ff;
      has_in    = has_ff;
      rcount_in = rcount_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (cmd.op_go) begin
         value_in  = '0;
         has_in    = 1'b0;
         rcount_in = cnt_next_ext[ple_pkg::COUNT_W-1:0];
         status_in = op_status;
         last_in   = 1'b1;
      end else if (cmd.elem_go) begin
         value_in  = entries_ff[cmd.elem_idx];
         has_in    = 1'b1;
         rcount_in = cnt_ext[ple_pkg::COUNT_W-1:0];
         status_in = ple_pkg::ST_OK;
         last_in   = cmd.elem_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
      value_ff   <= value_in;
      has_ff     <= has_in;
      rcount_ff  <= rcount_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

   assign rsp_element_value = value_ff;
   assign rsp_has_element   = has_ff;
   assign rsp_element_count = rcount_ff;
   assign rsp_status        = status_ff;
   assign rsp_last_result   = last_ff;

endmodule

>>> rtl/positional_list_engine.sv
// Insert, remove, clear: one result, valid the cycle after the transfer; a new
// request can be taken every cycle while the result register drains.
// Dump: the request is taken, then one element per cycle while not stalled, from
// the element register file (one empty result if empty), then the next request.
// Reset (synchronous, active high) empties the list and drops any pending result.
module positional_list_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ple_pkg::ACTION_W-1:0]  req_action,
   input  logic [ple_pkg::POS_W-1:0]     req_position,
   input  logic [ple_pkg::VALUE_W-1:0]   req_item_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ple_pkg::VALUE_W-1:0]   rsp_element_value,
   output logic                          rsp_has_element,
   output logic [ple_pkg::COUNT_W-1:0]   rsp_element_count,
   output logic [ple_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_last_result
);

   ple_pkg::cmd_type  cmd;
   ple_pkg::stat_type stat;

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   ple_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_element_value (rsp_element_value),
      .rsp_has_element   (rsp_has_element),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result)
   );

endmodule

>>> verif/positional_list_engine_tb.sv
module positional_list_engine_tb;

   typedef struct {
      logic [ple_pkg::VALUE_W-1:0]  value;
      logic                         has;
      logic [ple_pkg::COUNT_W-1:0]  count;
      logic [ple_pkg::STATUS_W-1:0] status;
      logic                         last;
   } list_result_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic [ple_pkg::ACTION_W-1:0]  req_action     = ple_pkg::ACT_CLEAR;
   logic [ple_pkg::POS_W-1:0]     req_position   = '0;
   logic [ple_pkg::VALUE_W-1:0]   req_item_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [ple_pkg::VALUE_W-1:0]   rsp_element_value;
   logic                          rsp_has_element;
   logic [ple_pkg::COUNT_W-1:0]   rsp_element_count;
   logic [ple_pkg::STATUS_W-1:0]  rsp_status;
   logic                          rsp_last_result;

   logic [ple_pkg::VALUE_W-1:0] list_words [ple_pkg::CAPACITY];
   int                          list_len = 0;
   list_result_type             pending_results [$];
   int                          mismatches = 0;
   bit                          no_idle = 1'b0;

   positional_list_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_has_element   (rsp_has_element),
      .rsp_element_count (rsp_element_count),
      .rsp_status        (rsp_status),
      .rsp_last_result   (rsp_last_result)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      mismatches++;
   endtask

   task automatic push_result(input logic [ple_pkg::VALUE_W-1:0] value, input logic has,
                              input logic [ple_pkg::STATUS_W-1:0] status,
                              input logic last);
      list_result_type r;
      r.value  = value;
      r.has    = has;
      r.count  = ple_pkg::COUNT_W'(list_len);
      r.status = status;
      r.last   = last;
      pending_results.push_back(r);
   endtask

   // updates the list copy and queues the results one action produces
   task automatic apply_to_list(input logic [ple_pkg::ACTION_W-1:0] act,
                                input logic [ple_pkg::POS_W-1:0] pos,
                                input logic [ple_pkg::VALUE_W-1:0] val);
      logic [ple_pkg::STATUS_W-1:0] st;
      int                           p;
      int                           i;
      st = ple_pkg::ST_OK;
      p  = int'(pos);
      if (act == ple_pkg::ACT_DUMP) begin
         if (list_len == 0) begin
            push_result('0, 1'b0, ple_pkg::ST_OK, 1'b1);
         end else begin
            for (i = 0; i < list_len; i++)
               push_result(list_words[i], 1'b1, ple_pkg::ST_OK, i == list_len - 1);
         end
      end else begin
         case (act)
            ple_pkg::ACT_INSERT: begin
               if (p > list_len) begin
                  st = ple_pkg::ST_RANGE;
               end else if (list_len >= ple_pkg::CAPACITY) begin
                  st = ple_pkg::ST_FULL;
               end else begin
                  for (i = list_len; i > p; i--)
                     list_words[i] = list_words[i-1];
                  list_words[p] = val;
                  list_len++;
               end
            end
            ple_pkg::ACT_REMOVE: begin
               if (p >= list_len) begin
                  st = ple_pkg::ST_RANGE;
               end else begin
                  for (i = p; i + 1 < list_len; i++)
                     list_words[i] = list_words[i+1];
                  list_len--;
               end
            end
            default: begin
               list_len = 0;
            end
         endcase
         push_result('0, 1'b0, st, 1'b1);
      end
   endtask

   task automatic send_item(input logic [ple_pkg::ACTION_W-1:0] act,
                            input logic [ple_pkg::POS_W-1:0] pos,
                            input logic [ple_pkg::VALUE_W-1:0] val);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_position   <= pos;
      req_item_value <= val;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      apply_to_list(act, pos, val);
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [ple_pkg::VALUE_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic test_empty_list();
      send_item(ple_pkg::ACT_DUMP, 5'd0, random_word());
      send_item(ple_pkg::ACT_REMOVE, 5'd0, random_word());
      send_item(ple_pkg::ACT_INSERT, 5'd1, random_word());
      send_item(ple_pkg::ACT_CLEAR, 5'd31, random_word());
   endtask

   task automatic test_fill_to_capacity();
      logic [ple_pkg::VALUE_W-1:0] val;
      logic [ple_pkg::POS_W-1:0]   pos;
      int                          k;
      for (k = 0; k < ple_pkg::CAPACITY; k++) begin
         case (k)
            0:       val = '0;
            1:       val = '1;
            2:       val = {16{4'h5}};
            3:       val = {16{4'hA}};
            default: val = random_word();
         endcase
         case (k % 3)
            0:       pos = '0;
            1:       pos = ple_pkg::POS_W'(list_len);
            default: pos = ple_pkg::POS_W'(list_len / 2);
         endcase
         send_item(ple_pkg::ACT_INSERT, pos, val);
      end
      send_item(ple_pkg::ACT_INSERT, 5'd16, random_word());
      send_item(ple_pkg::ACT_INSERT, 5'd17, random_word());
      send_item(ple_pkg::ACT_DUMP, 5'd31, '1);
   endtask

   task automatic test_remove_and_clear();
      send_item(ple_pkg::ACT_REMOVE, 5'd16, random_word());
      send_item(ple_pkg::ACT_REMOVE, 5'd15, random_word());
      send_item(ple_pkg::ACT_REMOVE, 5'd7, random_word());
      send_item(ple_pkg::ACT_REMOVE, 5'd0, random_word());
      send_item(ple_pkg::ACT_DUMP, 5'd0, random_word());
      send_item(ple_pkg::ACT_CLEAR, 5'd0, random_word());
      send_item(ple_pkg::ACT_DUMP, 5'd0, random_word());
   endtask

   task automatic test_random_traffic();
      int                           grow_pct [6] = '{60, 45, 70, 40, 55, 65};
      int                           phase;
      int                           n;
      int                           roll;
      logic [ple_pkg::ACTION_W-1:0] act;
      logic [ple_pkg::POS_W-1:0]    pos;
      for (phase = 0; phase < 6; phase++) begin
         no_idle = phase[0];
         for (n = 0; n < 60; n++) begin
            roll = $urandom_range(0, 99);
            pos  = ple_pkg::POS_W'($urandom_range(0, 31));
            if (roll < 8) begin
               act = ple_pkg::ACTION_W'($urandom_range(0, 3));
            end else if (roll < 8 + grow_pct[phase]) begin
               act = ple_pkg::ACT_INSERT;
               pos = ple_pkg::POS_W'($urandom_range(0, list_len));
            end else if (roll < 88) begin
               act = ple_pkg::ACT_REMOVE;
               pos = (list_len == 0) ? '0
                                     : ple_pkg::POS_W'($urandom_range(0, list_len - 1));
            end else if (roll < 97) begin
               act = ple_pkg::ACT_DUMP;
            end else begin
               act = ple_pkg::ACT_CLEAR;
            end
            send_item(act, pos, random_word());
         end
         wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      list_result_type want;
      int              n;
      wait (reset == 1'b0);
      forever begin
         n = no_idle ? 0 : $urandom_range(0, 19);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid)
            @(posedge clock);
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_element_value, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_element_value !== want.value)
               report_mismatch("element_value", rsp_element_value, want.value);
            if (rsp_has_element !== want.has)
               report_mismatch("has_element", 64'(rsp_has_element), 64'(want.has));
            if (rsp_element_count !== want.count)
               report_mismatch("element_count", 64'(rsp_element_count), 64'(want.count));
            if (rsp_status !== want.status)
               report_mismatch("status", 64'(rsp_status), 64'(want.status));
            if (rsp_last_result !== want.last)
               report_mismatch("last_result", 64'(rsp_last_result), 64'(want.last));
         end
      end
   end

   initial begin
      #2000000;
      $display("positional_list_engine_tb NOT OK");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      wait_drained();
      test_fill_to_capacity();
      wait_drained();
      test_remove_and_clear();
      wait_drained();
      test_random_traffic();
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("positional_list_engine_tb OK");
      else
         $display("positional_list_engine_tb NOT OK");
      $finish;
   end

endmodule
